### rtl/uad_pkg.sv
// shared types and constants for the ultrasonic avoidance drive controller
// used by uad_front, uad_back and the top level; no dependencies
package uad_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int RDEPTH = 2;
  localparam int RAW = $clog2(RDEPTH);

  localparam logic [2:0] MODE_STOP = 3'd0;
  localparam logic [2:0] MODE_SCAN = 3'd1;
  localparam logic [2:0] MODE_PIVOT = 3'd2;
  localparam logic [2:0] MODE_HOLD = 3'd3;
  localparam logic [2:0] MODE_BACK = 3'd4;

  localparam logic [1:0] DIR_FORWARD = 2'd0;
  localparam logic [1:0] DIR_BACK = 2'd1;
  localparam logic [1:0] DIR_PIVOT_LEFT = 2'd2;
  localparam logic [1:0] DIR_PIVOT_RIGHT = 2'd3;

  localparam logic [6:0] SPD_STOP = 7'd0;
  localparam logic [6:0] SPD_FORWARD = 7'd65;
  localparam logic [6:0] SPD_PIVOT = 7'd100;
  localparam logic [6:0] SPD_BACK_SCAN = 7'd70;
  localparam logic [6:0] SPD_BACK_HOLD = 7'd50;

  localparam logic [2:0] REG_FRONT_BLOCK = 3'd0;
  localparam logic [2:0] REG_SIDE_BLOCK = 3'd1;
  localparam logic [2:0] REG_CRASH = 3'd2;
  localparam logic [2:0] REG_MAX_RANGE = 3'd3;
  localparam logic [2:0] REG_PIVOT = 3'd4;
  localparam logic [2:0] REG_HOLD = 3'd5;
  localparam logic [2:0] REG_REVERSE = 3'd6;

  localparam logic [7:0] RST_FRONT_BLOCK = 8'd30;
  localparam logic [7:0] RST_SIDE_BLOCK = 8'd10;
  localparam logic [7:0] RST_CRASH = 8'd10;
  localparam logic [7:0] RST_MAX_RANGE = 8'd100;
  localparam logic [15:0] RST_PIVOT = 16'd150;
  localparam logic [15:0] RST_HOLD = 16'd100;
  localparam logic [15:0] RST_REVERSE = 16'd250;

  typedef struct packed {
    logic [7:0] front_block_cm;
    logic [7:0] side_block_cm;
    logic [7:0] crash_cm;
    logic [7:0] max_range_cm;
    logic [15:0] pivot_ms;
    logic [15:0] hold_ms;
    logic [15:0] reverse_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic crash;
    logic correct;
    logic [1:0] pivot_dir;
  } item_t;

  typedef struct packed {
    logic is_stop;
    logic [1:0] direction;
    logic [6:0] speed_pct;
  } result_t;

endpackage

### rtl/ultrasonic_avoidance_drive_fsm_unit.sv
// Obstacle-avoidance drive controller. One control tick (timestamp plus left,
// center and right distances) can be pushed every clock cycle while full is
// low. The front part clamps and classifies the tick in the cycle it is
// pushed and stores it in a four-entry command queue; the back part runs the
// mode machine on one queued tick per cycle while the result queue has room
// or is popped, and writes at most one command into a two-entry result queue.
// A command passes through both queues; full rises only when both queues are
// backed up by pop. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; indexes beyond the register list are ignored.
// depends on uad_pkg, uad_front and uad_back
module ultrasonic_avoidance_drive_fsm_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic [31:0] now_ms,
  input  logic [7:0] left_raw_cm,
  input  logic [7:0] center_raw_cm,
  input  logic [7:0] right_raw_cm,
  output logic empty,
  input  logic pop,
  output logic is_stop,
  output logic [1:0] direction,
  output logic [6:0] speed_pct
);

  uad_pkg::cfg_t cfg;
  uad_pkg::item_t item;
  logic item_valid;
  logic item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_block_cm <= uad_pkg::RST_FRONT_BLOCK;
      cfg.side_block_cm <= uad_pkg::RST_SIDE_BLOCK;
      cfg.crash_cm <= uad_pkg::RST_CRASH;
      cfg.max_range_cm <= uad_pkg::RST_MAX_RANGE;
      cfg.pivot_ms <= uad_pkg::RST_PIVOT;
      cfg.hold_ms <= uad_pkg::RST_HOLD;
      cfg.reverse_ms <= uad_pkg::RST_REVERSE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uad_pkg::REG_FRONT_BLOCK: cfg.front_block_cm <= cfg_data[7:0];
        uad_pkg::REG_SIDE_BLOCK: cfg.side_block_cm <= cfg_data[7:0];
        uad_pkg::REG_CRASH: cfg.crash_cm <= cfg_data[7:0];
        uad_pkg::REG_MAX_RANGE: cfg.max_range_cm <= cfg_data[7:0];
        uad_pkg::REG_PIVOT: cfg.pivot_ms <= cfg_data;
        uad_pkg::REG_HOLD: cfg.hold_ms <= cfg_data;
        uad_pkg::REG_REVERSE: cfg.reverse_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  uad_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .push(push),
    .full(full),
    .now_ms(now_ms),
    .left_raw_cm(left_raw_cm),
    .center_raw_cm(center_raw_cm),
    .right_raw_cm(right_raw_cm),
    .item_valid(item_valid),
    .item(item),
    .item_take(item_take)
  );

  uad_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .item_valid(item_valid),
    .item(item),
    .item_take(item_take),
    .empty(empty),
    .pop(pop),
    .is_stop(is_stop),
    .direction(direction),
    .speed_pct(speed_pct)
  );

endmodule

### rtl/uad_front.sv
// front part: clamps the three readings, classifies the tick and queues it
// depends on uad_pkg
module uad_front (
  input  logic clk,
  input  logic rst,
  input  uad_pkg::cfg_t cfg,
  input  logic push,
  output logic full,
  input  logic [31:0] now_ms,
  input  logic [7:0] left_raw_cm,
  input  logic [7:0] center_raw_cm,
  input  logic [7:0] right_raw_cm,
  output logic item_valid,
  output uad_pkg::item_t item,
  input  logic item_take
);

  uad_pkg::item_t mem [uad_pkg::QDEPTH];
  logic [uad_pkg::QAW-1:0] wptr;
  logic [uad_pkg::QAW-1:0] rptr;
  logic [uad_pkg::QAW:0] count;
  logic [7:0] l;
  logic [7:0] c;
  logic [7:0] r;
  logic ld;
  logic rd;
  logic wr;
  logic rd_fire;
  uad_pkg::item_t cls;

  function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] mx);
    clamp = (v == 8'd0 || v > mx) ? mx : v;
  endfunction

  always_comb begin
    l = clamp(left_raw_cm, cfg.max_range_cm);
    c = clamp(center_raw_cm, cfg.max_range_cm);
    r = clamp(right_raw_cm, cfg.max_range_cm);
    ld = l < cfg.side_block_cm;
    rd = r < cfg.side_block_cm;
    cls.now_ms = now_ms;
    cls.crash = c < cfg.crash_cm;
    cls.correct = (c < cfg.front_block_cm) || ld || rd;
    if (ld != rd) begin
      cls.pivot_dir = ld ? uad_pkg::DIR_PIVOT_RIGHT : uad_pkg::DIR_PIVOT_LEFT;
    end else begin
      cls.pivot_dir = (l <= r) ? uad_pkg::DIR_PIVOT_RIGHT : uad_pkg::DIR_PIVOT_LEFT;
    end
  end

  assign full = (count == (uad_pkg::QAW+1)'(uad_pkg::QDEPTH));
  assign item_valid = (count != '0);
  assign item = mem[rptr];
  assign wr = push && !full;
  assign rd_fire = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_fire) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd_fire) begin
        count <= count + 1'b1;
      end else if (rd_fire && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (uad_pkg::QAW+1)'(uad_pkg::QDEPTH))
    else $error("command queue overfilled");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd_fire) |=> count == $past(count) + 1'b1)
    else $error("command queue count lost a write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (rd_fire && !wr) |=> count == $past(count) - 1'b1)
    else $error("command queue count lost a read");

endmodule

### rtl/uad_back.sv
// back part: mode machine with timers, and the result queue
// depends on uad_pkg
module uad_back (
  input  logic clk,
  input  logic rst,
  input  uad_pkg::cfg_t cfg,
  input  logic item_valid,
  input  uad_pkg::item_t item,
  output logic item_take,
  output logic empty,
  input  logic pop,
  output logic is_stop,
  output logic [1:0] direction,
  output logic [6:0] speed_pct
);

  logic [2:0] mode;
  logic [2:0] mode_next;
  logic [31:0] mode_start_ms;
  logic [31:0] mode_start_ms_next;
  logic [31:0] elapsed;
  logic emit;
  uad_pkg::result_t res;
  uad_pkg::result_t rmem [uad_pkg::RDEPTH];
  logic [uad_pkg::RAW-1:0] rwptr;
  logic [uad_pkg::RAW-1:0] rrptr;
  logic [uad_pkg::RAW:0] rcount;
  logic pop_fire;
  logic res_wr;

  assign pop_fire = pop && !empty;
  assign empty = (rcount == '0);
  assign item_take = item_valid &&
    (rcount != (uad_pkg::RAW+1)'(uad_pkg::RDEPTH) || pop_fire);
  assign res_wr = item_take && emit;
  assign elapsed = item.now_ms - mode_start_ms;
  assign is_stop = rmem[rrptr].is_stop;
  assign direction = rmem[rrptr].direction;
  assign speed_pct = rmem[rrptr].speed_pct;

  always_comb begin
    mode_next = mode;
    mode_start_ms_next = mode_start_ms;
    emit = 1'b0;
    res = '{is_stop: 1'b0, direction: uad_pkg::DIR_FORWARD, speed_pct: uad_pkg::SPD_FORWARD};
    unique case (mode)
      uad_pkg::MODE_SCAN: begin
        emit = 1'b1;
        if (item.crash) begin
          mode_next = uad_pkg::MODE_BACK;
          mode_start_ms_next = item.now_ms;
          res.direction = uad_pkg::DIR_BACK;
          res.speed_pct = uad_pkg::SPD_BACK_SCAN;
        end else if (item.correct) begin
          mode_next = uad_pkg::MODE_PIVOT;
          mode_start_ms_next = item.now_ms;
          res.direction = item.pivot_dir;
          res.speed_pct = uad_pkg::SPD_PIVOT;
        end
      end
      uad_pkg::MODE_PIVOT: begin
        if (elapsed >= {16'd0, cfg.pivot_ms}) begin
          emit = 1'b1;
          mode_start_ms_next = item.now_ms;
          if (item.correct) begin
            res.direction = item.pivot_dir;
            res.speed_pct = uad_pkg::SPD_PIVOT;
          end else begin
            mode_next = uad_pkg::MODE_HOLD;
          end
        end
      end
      uad_pkg::MODE_HOLD: begin
        if (item.crash) begin
          emit = 1'b1;
          mode_next = uad_pkg::MODE_BACK;
          mode_start_ms_next = item.now_ms;
          res.direction = uad_pkg::DIR_BACK;
          res.speed_pct = uad_pkg::SPD_BACK_HOLD;
        end else if (item.correct) begin
          emit = 1'b1;
          mode_next = uad_pkg::MODE_PIVOT;
          mode_start_ms_next = item.now_ms;
          res.direction = item.pivot_dir;
          res.speed_pct = uad_pkg::SPD_PIVOT;
        end else if (elapsed >= {16'd0, cfg.hold_ms}) begin
          mode_next = uad_pkg::MODE_SCAN;
        end
      end
      uad_pkg::MODE_BACK: begin
        if (elapsed >= {16'd0, cfg.reverse_ms}) begin
          emit = 1'b1;
          mode_next = uad_pkg::MODE_SCAN;
          res.is_stop = 1'b1;
          res.direction = uad_pkg::DIR_FORWARD;
          res.speed_pct = uad_pkg::SPD_STOP;
        end
      end
      default: begin
        mode_next = uad_pkg::MODE_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= uad_pkg::MODE_STOP;
      mode_start_ms <= '0;
    end else if (item_take) begin
      mode <= mode_next;
      mode_start_ms <= mode_start_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      rmem[rwptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwptr <= '0;
      rrptr <= '0;
      rcount <= '0;
    end else begin
      if (res_wr) begin
        rwptr <= rwptr + 1'b1;
      end
      if (pop_fire) begin
        rrptr <= rrptr + 1'b1;
      end
      if (res_wr && !pop_fire) begin
        rcount <= rcount + 1'b1;
      end else if (pop_fire && !res_wr) begin
        rcount <= rcount - 1'b1;
      end
    end
  end

  a_rcount_range: assert property (@(posedge clk) disable iff (rst)
    rcount <= (uad_pkg::RAW+1)'(uad_pkg::RDEPTH))
    else $error("result queue overfilled");
  a_stop_from_back: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res.is_stop) |-> mode == uad_pkg::MODE_BACK)
    else $error("stop command outside reverse");
  a_idle_to_scan: assert property (@(posedge clk) disable iff (rst)
    (item_take && mode == uad_pkg::MODE_STOP) |=> mode == uad_pkg::MODE_SCAN)
    else $error("stop mode did not move to scan");
  a_hold_silent_exit: assert property (@(posedge clk) disable iff (rst)
    (item_take && mode == uad_pkg::MODE_HOLD && mode_next == uad_pkg::MODE_SCAN)
      |-> !emit)
    else $error("hold exit produced a command");

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the ultrasonic avoidance drive controller
// drives control ticks through the push/full port, predicts each drive or stop
// command and checks it at the pop/empty port; depends on uad_pkg and the rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uad_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 120;

  typedef struct packed {
    logic [31:0] now;
    logic [7:0] l;
    logic [7:0] c;
    logic [7:0] r;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [31:0] now_ms = '0;
  logic [7:0] left_raw_cm = '0;
  logic [7:0] center_raw_cm = '0;
  logic [7:0] right_raw_cm = '0;
  logic empty;
  logic pop = 1'b0;
  logic is_stop;
  logic [1:0] direction;
  logic [6:0] speed_pct;

  ultrasonic_avoidance_drive_fsm_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .now_ms(now_ms),
    .left_raw_cm(left_raw_cm),
    .center_raw_cm(center_raw_cm),
    .right_raw_cm(right_raw_cm),
    .empty(empty),
    .pop(pop),
    .is_stop(is_stop),
    .direction(direction),
    .speed_pct(speed_pct)
  );

  tick_t tick_q[$];
  result_t command_due[$];
  result_t oldest_cmd;
  cfg_t regs = '{RST_FRONT_BLOCK, RST_SIDE_BLOCK, RST_CRASH, RST_MAX_RANGE,
                 RST_PIVOT, RST_HOLD, RST_REVERSE};
  logic [2:0] drive_mode = MODE_STOP;
  logic [31:0] drive_start = '0;
  logic [31:0] clock_ms = 32'hFFFF_FF00;
  bit quiet = 1'b0;
  int mismatches = 0;
  int got_count = 0;
  int next_hold_at = 150;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // drive command prediction
  function automatic logic [7:0] clamp_cm(logic [7:0] raw);
    if (raw == 8'd0 || raw > regs.max_range_cm) return regs.max_range_cm;
    return raw;
  endfunction

  function automatic bit needs_turn(logic [7:0] l, logic [7:0] c, logic [7:0] r);
    return c < regs.front_block_cm || l < regs.side_block_cm || r < regs.side_block_cm;
  endfunction

  function automatic logic [1:0] turn_dir(logic [7:0] l, logic [7:0] r);
    bit ld, rd;
    ld = l < regs.side_block_cm;
    rd = r < regs.side_block_cm;
    if (ld && !rd) return DIR_PIVOT_RIGHT;
    if (rd && !ld) return DIR_PIVOT_LEFT;
    if (ld && rd) return (l <= r) ? DIR_PIVOT_RIGHT : DIR_PIVOT_LEFT;
    return (r >= l) ? DIR_PIVOT_RIGHT : DIR_PIVOT_LEFT;
  endfunction

  task automatic plan_drive(logic [31:0] t, logic [7:0] lr, logic [7:0] cr, logic [7:0] rr);
    logic [7:0] l, c, r;
    logic [31:0] gone;
    result_t cmd;
    bit fires;
    l = clamp_cm(lr);
    c = clamp_cm(cr);
    r = clamp_cm(rr);
    gone = t - drive_start;
    fires = 1'b0;
    cmd = '0;
    case (drive_mode)
      MODE_SCAN: begin
        fires = 1'b1;
        if (c < regs.crash_cm) begin
          drive_start = t;
          drive_mode = MODE_BACK;
          cmd = '{1'b0, DIR_BACK, SPD_BACK_SCAN};
        end else if (needs_turn(l, c, r)) begin
          drive_start = t;
          drive_mode = MODE_PIVOT;
          cmd = '{1'b0, turn_dir(l, r), SPD_PIVOT};
        end else begin
          cmd = '{1'b0, DIR_FORWARD, SPD_FORWARD};
        end
      end
      MODE_PIVOT: begin
        if (gone >= regs.pivot_ms) begin
          fires = 1'b1;
          drive_start = t;
          if (needs_turn(l, c, r)) begin
            cmd = '{1'b0, turn_dir(l, r), SPD_PIVOT};
          end else begin
            drive_mode = MODE_HOLD;
            cmd = '{1'b0, DIR_FORWARD, SPD_FORWARD};
          end
        end
      end
      MODE_HOLD: begin
        if (c < regs.crash_cm) begin
          fires = 1'b1;
          drive_start = t;
          drive_mode = MODE_BACK;
          cmd = '{1'b0, DIR_BACK, SPD_BACK_HOLD};
        end else if (needs_turn(l, c, r)) begin
          fires = 1'b1;
          drive_start = t;
          drive_mode = MODE_PIVOT;
          cmd = '{1'b0, turn_dir(l, r), SPD_PIVOT};
        end else if (gone >= regs.hold_ms) begin
          drive_mode = MODE_SCAN;
        end
      end
      MODE_BACK: begin
        if (gone >= regs.reverse_ms) begin
          fires = 1'b1;
          drive_mode = MODE_SCAN;
          cmd = '{1'b1, DIR_FORWARD, SPD_STOP};
        end
      end
      default: begin
        drive_mode = MODE_SCAN;
      end
    endcase
    if (fires) command_due.push_back(cmd);
  endtask

  // stimulus helpers
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRONT_BLOCK: regs.front_block_cm = val[7:0];
      REG_SIDE_BLOCK: regs.side_block_cm = val[7:0];
      REG_CRASH: regs.crash_cm = val[7:0];
      REG_MAX_RANGE: regs.max_range_cm = val[7:0];
      REG_PIVOT: regs.pivot_ms = val;
      REG_HOLD: regs.hold_ms = val;
      REG_REVERSE: regs.reverse_ms = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] fb, logic [15:0] sb, logic [15:0] cr,
                           logic [15:0] mr, logic [15:0] pv, logic [15:0] hd,
                           logic [15:0] rv);
    write_reg(REG_FRONT_BLOCK, fb);
    write_reg(REG_SIDE_BLOCK, sb);
    write_reg(REG_CRASH, cr);
    write_reg(REG_MAX_RANGE, mr);
    write_reg(REG_PIVOT, pv);
    write_reg(REG_HOLD, hd);
    write_reg(REG_REVERSE, rv);
  endtask

  function automatic logic [15:0] random_timer();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 400));
  endfunction

  task automatic random_regs();
    write_all({8'($urandom()), 8'($urandom_range(0, 80))},
              {8'($urandom()), 8'($urandom_range(0, 40))},
              {8'($urandom()), 8'($urandom_range(0, 40))},
              {8'($urandom()), 8'($urandom_range(1, 255))},
              random_timer(), random_timer(), random_timer());
    write_reg(REG_NONE, 16'($urandom()));
  endtask

  function automatic logic [31:0] next_step();
    int unsigned top;
    top = regs.pivot_ms;
    if (regs.hold_ms > top) top = regs.hold_ms;
    if (regs.reverse_ms > top) top = regs.reverse_ms;
    case ($urandom_range(0, 19))
      0: return $urandom();
      1, 2, 3, 4, 5: return $urandom_range(0, top + 40);
      default: return $urandom_range(0, top / 2 + 20);
    endcase
  endfunction

  function automatic logic [7:0] pick_cm(int unsigned near);
    int unsigned lo, hi;
    lo = (near > 4) ? near - 4 : 0;
    hi = (near + 4 > 255) ? 255 : near + 4;
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1, 2, 3: return 8'($urandom_range(0, 255));
      4, 5, 6: return 8'($urandom_range(lo, hi));
      default: return 8'($urandom_range(0, (regs.max_range_cm + 20 > 255) ? 255
                                             : regs.max_range_cm + 20));
    endcase
  endfunction

  task automatic add_tick(int unsigned dt, logic [7:0] l, logic [7:0] c, logic [7:0] r);
    clock_ms = clock_ms + dt;
    tick_q.push_back('{clock_ms, l, c, r});
  endtask

  task automatic add_random(int n);
    int unsigned cnear;
    repeat (n) begin
      cnear = $urandom_range(0, 1) ? regs.front_block_cm : regs.crash_cm;
      add_tick(next_step(), pick_cm(regs.side_block_cm), pick_cm(cnear),
               pick_cm(regs.side_block_cm));
    end
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || command_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ticks in
  always @(negedge clk) begin
    if (rst || tick_q.size() == 0 || (!quiet && $urandom_range(0, 99) < 8)) begin
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      now_ms <= tick_q[0].now;
      left_raw_cm <= tick_q[0].l;
      center_raw_cm <= tick_q[0].c;
      right_raw_cm <= tick_q[0].r;
    end
  end

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      plan_drive(now_ms, left_raw_cm, center_raw_cm, right_raw_cm);
      void'(tick_q.pop_front());
    end
  end

  // commands out, with an occasional long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (got_count >= next_hold_at) begin
      pop <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      next_hold_at <= next_hold_at + 400;
    end else begin
      pop <= quiet || ($urandom_range(0, 99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      got_count <= got_count + 1;
      if (command_due.size() == 0) begin
        $error("command transfer with nothing pending");
        mismatches++;
      end else begin
        oldest_cmd = command_due.pop_front();
        if (is_stop !== oldest_cmd.is_stop) begin
          $error("is_stop: wanted %0d got %0d", oldest_cmd.is_stop, is_stop);
          mismatches++;
        end
        if (direction !== oldest_cmd.direction) begin
          $error("direction: wanted %0d got %0d", oldest_cmd.direction, direction);
          mismatches++;
        end
        if (speed_pct !== oldest_cmd.speed_pct) begin
          $error("speed_pct: wanted %0d got %0d", oldest_cmd.speed_pct, speed_pct);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, walk every mode transition, across the timestamp wrap
    add_tick(0, 50, 50, 50);
    add_tick(10, 0, 255, 200);
    add_tick(10, 50, 5, 50);
    add_tick(80, 50, 50, 50);
    add_tick(170, 50, 50, 50);
    add_tick(10, 5, 50, 50);
    add_tick(50, 50, 50, 50);
    add_tick(110, 50, 50, 3);
    add_tick(150, 8, 50, 4);
    add_tick(150, 4, 50, 8);
    add_tick(150, 60, 20, 40);
    add_tick(150, 40, 20, 60);
    add_tick(150, 50, 50, 50);
    add_tick(10, 50, 5, 50);
    add_tick(250, 50, 50, 50);
    add_tick(10, 50, 50, 50);
    add_tick(10, 50, 25, 50);
    add_tick(150, 50, 50, 50);
    add_tick(50, 9, 50, 50);
    add_tick(150, 50, 50, 50);
    add_tick(99, 50, 50, 50);
    add_tick(1, 50, 50, 50);
    add_tick(5, 50, 50, 50);
    add_tick(5, 101, 255, 0);
    drain();

    write_all(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    add_random(140);
    drain();

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random(140);
    drain();

    // max range of zero clamps every reading to zero
    random_regs();
    write_reg(REG_MAX_RANGE, 16'd0);
    add_random(140);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      random_regs();
      quiet = (ph == 2);
      add_random(140);
      drain();
    end
    quiet = 1'b0;

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
